// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clk edge outside of reset.
`define RSAS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never holds outside of reset.
`define RSAS_NEVER(lbl, cond, msg) \
    `RSAS_ASSERT(lbl, !(cond), msg)

`endif

// ===== rtl/rsas_pkg.sv =====
// ---------------------------------------------------------------------------
// rsas_pkg
// Shared constants and types for the rotated sorted array search block.
// ---------------------------------------------------------------------------
package rsas_pkg;

    localparam int ENTRIES = 1024;
    localparam int ADDR_W  = $clog2(ENTRIES);
    localparam int CNT_W   = ADDR_W + 1;
    localparam int DATA_W  = 32;
    localparam int POS_W   = 10;

    // Command codes
    localparam logic [1:0] CMD_APPEND = 2'd0;
    localparam logic [1:0] CMD_SEARCH = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;

    // Request from the sequencer to the element store
    typedef struct packed {
        logic                     we;
        logic [ADDR_W-1:0]        waddr;
        logic signed [DATA_W-1:0] wdata;
        logic [ADDR_W-1:0]        raddr;
    } mem_req_t;

endpackage

// ===== rtl/rsas_store.sv =====
// ---------------------------------------------------------------------------
// rsas_store
// Element store: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module rsas_store
    import rsas_pkg::*;
(
    input  logic                     clk,
    input  mem_req_t                 req,
    output logic signed [DATA_W-1:0] rdata
);

    logic signed [DATA_W-1:0] mem [ENTRIES];

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[req.raddr];
    end

endmodule

// ===== rtl/rsas_ctrl.sv =====
// ---------------------------------------------------------------------------
// rsas_ctrl
// Command decode, element count and the binary search sequencer.
// ---------------------------------------------------------------------------
module rsas_ctrl
    import rsas_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [1:0]               cmd,
    input  logic signed [DATA_W-1:0] value,
    output logic                     busy,
    output logic                     done,
    output logic                     found,
    output logic [POS_W-1:0]         position,
    output mem_req_t                 mem_req,
    input  logic signed [DATA_W-1:0] mem_rdata
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CHECK = 3'd1;
    localparam logic [2:0] ST_RD_LO = 3'd2;
    localparam logic [2:0] ST_RD_HI = 3'd3;
    localparam logic [2:0] ST_EVAL  = 3'd4;

    logic [2:0]               state_reg, state_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic [CNT_W-1:0]         lo_reg, lo_next;
    // upper bound kept as hi + 1 so an empty range needs no negative value
    logic [CNT_W-1:0]         hip1_reg, hip1_next;
    logic [ADDR_W-1:0]        mid_reg, mid_next;
    logic signed [DATA_W-1:0] target_reg, target_next;
    logic signed [DATA_W-1:0] vmid_reg, vmid_next;
    logic signed [DATA_W-1:0] vlo_reg, vlo_next;
    logic                     done_reg, done_next;
    logic                     found_reg, found_next;
    logic [POS_W-1:0]         pos_reg, pos_next;

    logic                     accept;
    logic [CNT_W-1:0]         sum;
    logic [ADDR_W-1:0]        mid_calc;
    logic [CNT_W-1:0]         hi_val;
    logic signed [DATA_W-1:0] vhi;
    logic                     go_high;

    assign accept   = start && (state_reg == ST_IDLE);
    assign sum      = lo_reg + hip1_reg - CNT_W'(1);
    assign mid_calc = sum[CNT_W-1:1];
    assign hi_val   = hip1_reg - CNT_W'(1);
    assign vhi      = mem_rdata;

    // Pick the half that holds the target
    always_comb
    begin
        if (vlo_reg <= vmid_reg)
        begin
            go_high = !((vlo_reg <= target_reg) && (target_reg < vmid_reg));
        end
        else
        begin
            go_high = (vmid_reg < target_reg) && (target_reg <= vhi);
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        lo_next       = lo_reg;
        hip1_next     = hip1_reg;
        mid_next      = mid_reg;
        target_next   = target_reg;
        vmid_next     = vmid_reg;
        vlo_next      = vlo_reg;
        done_next     = 1'b0;
        found_next    = found_reg;
        pos_next      = pos_reg;
        mem_req.we    = 1'b0;
        mem_req.waddr = count_reg[ADDR_W-1:0];
        mem_req.wdata = value;
        mem_req.raddr = mid_calc;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (cmd)
                        CMD_APPEND:
                        begin
                            if (count_reg < CNT_W'(ENTRIES))
                            begin
                                mem_req.we = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        CMD_SEARCH:
                        begin
                            target_next = value;
                            lo_next     = '0;
                            hip1_next   = count_reg;
                            state_next  = ST_CHECK;
                        end
                        CMD_CLEAR:
                        begin
                            count_next = '0;
                        end
                        default:
                        begin
                            count_next = count_reg;
                        end
                    endcase
                end
            end
            ST_CHECK:
            begin
                if (lo_reg < hip1_reg)
                begin
                    mem_req.raddr = mid_calc;
                    mid_next      = mid_calc;
                    state_next    = ST_RD_LO;
                end
                else
                begin
                    done_next  = 1'b1;
                    found_next = 1'b0;
                    pos_next   = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_RD_LO:
            begin
                mem_req.raddr = lo_reg[ADDR_W-1:0];
                vmid_next     = mem_rdata;
                state_next    = ST_RD_HI;
            end
            ST_RD_HI:
            begin
                mem_req.raddr = hi_val[ADDR_W-1:0];
                vlo_next      = mem_rdata;
                state_next    = ST_EVAL;
            end
            ST_EVAL:
            begin
                if (vmid_reg == target_reg)
                begin
                    done_next  = 1'b1;
                    found_next = 1'b1;
                    pos_next   = POS_W'(mid_reg);
                    state_next = ST_IDLE;
                end
                else
                begin
                    if (go_high)
                    begin
                        lo_next = CNT_W'(mid_reg) + CNT_W'(1);
                    end
                    else
                    begin
                        hip1_next = CNT_W'(mid_reg);
                    end
                    state_next = ST_CHECK;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg     <= lo_next;
        hip1_reg   <= hip1_next;
        mid_reg    <= mid_next;
        target_reg <= target_next;
        vmid_reg   <= vmid_next;
        vlo_reg    <= vlo_next;
        found_reg  <= found_next;
        pos_reg    <= pos_next;
    end

    assign busy     = (state_reg != ST_IDLE);
    assign done     = done_reg;
    assign found    = found_reg;
    assign position = pos_reg;

endmodule

// ===== rtl/rotated_sorted_array_search.sv =====
// ---------------------------------------------------------------------------
// rotated_sorted_array_search
// Append and clear give no result and leave busy low.
// A search raises done from the evaluate state on a hit and from the check
// state on a miss, after at most 11 steps for 1024 entries. Each step makes
// three reads on the single read port of the store and one evaluate state;
// busy drops with done, so a new transfer can be taken in the done cycle.
// Reset clears the element count and the sequencer; the store is not cleared.
// ---------------------------------------------------------------------------
module rotated_sorted_array_search
    import rsas_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [1:0]               cmd,
    input  logic signed [DATA_W-1:0] value,
    output logic                     done,
    output logic                     found,
    output logic [POS_W-1:0]         position
);

    mem_req_t                 mem_req;
    logic signed [DATA_W-1:0] mem_rdata;

    // Writes happen only while idle, so reads and writes never overlap
    rsas_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .cmd       (cmd),
        .value     (value),
        .busy      (busy),
        .done      (done),
        .found     (found),
        .position  (position),
        .mem_req   (mem_req),
        .mem_rdata (mem_rdata)
    );

    rsas_store u_store (
        .clk   (clk),
        .req   (mem_req),
        .rdata (mem_rdata)
    );

endmodule

// ===== rtl/rsas_checker.sv =====
// ---------------------------------------------------------------------------
// rsas_checker
// Port-level checks for the rotated sorted array search block.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module rsas_checker
    import rsas_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     start,
    input logic                     busy,
    input logic [1:0]               cmd,
    input logic                     done,
    input logic                     found,
    input logic [POS_W-1:0]         position
);

    logic search_xfer;
    logic other_xfer;

    assign search_xfer = start && !busy && (cmd == CMD_SEARCH);
    assign other_xfer  = start && !busy && (cmd != CMD_SEARCH);

    `RSAS_ASSERT(a_miss_pos_zero, (done && !found) |-> (position == '0),
        "miss result with nonzero position")
    `RSAS_ASSERT(a_done_single, done |=> !done, "result strobe longer than one cycle")
    `RSAS_ASSERT(a_search_busy, search_xfer |=> busy, "search transfer did not raise busy")
    `RSAS_ASSERT(a_other_quiet, other_xfer |=> (!busy && !done),
        "append or clear raised busy or gave a result")
    `RSAS_NEVER(a_done_busy, done && busy && $past(done), "result while busy after result")

endmodule

bind rotated_sorted_array_search rsas_checker u_rsas_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .cmd      (cmd),
    .done     (done),
    .found    (found),
    .position (position)
);
